// ===== rtl/core/msc_pkg.sv =====
// Shared types and constants for the microstep sine/cosine sequencer.
// Holds the transaction structs, opcode and register index codes and defaults.
// No dependencies; the top level, msc_seq and the testbench import this package.
package msc_pkg;

  // Default sizing, handed to the top-level parameters.
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int LEVEL_WIDTH_DEF = 16;

  // Configuration port layout.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_POINTS    = 2'd0;
  localparam cfg_index_t CFG_IDLE_SINE = 2'd1;
  localparam cfg_index_t CFG_IDLE_COS  = 2'd2;

  // Points register: width, reset value and lower clamp.
  localparam int          POINTS_W     = 11;
  localparam logic [10:0] POINTS_RESET = 11'd10;
  localparam logic [10:0] MIN_POINTS   = 11'd10;

  // Opcodes of an input transaction; code 3 is ignored.
  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_TICK  = 2'd0;
  localparam opcode_t OP_SET   = 2'd1;
  localparam opcode_t OP_WRITE = 2'd2;

  // Input transaction.
  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] step_count;
    logic        [9:0]  entry_index;
    logic signed [15:0] sine_entry;
    logic signed [15:0] cosine_entry;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic signed [15:0] sine_drive;
    logic signed [15:0] cosine_drive;
    logic signed [31:0] steps_remaining;
  } out_item_t;

  // Status from the step sequencer for the tick being accepted.
  typedef struct packed {
    logic               idle;
    logic signed [31:0] steps_after;
  } seq_info_t;

endpackage

// ===== rtl/core/microstep_sine_cosine_sequencer_unit.sv =====
// Microstep sine/cosine sequencer top level: config registers, table RAM, pipeline.
// Depends on msc_pkg, msc_ram and msc_seq.
//
// Usage:
//   Input channel (in_valid/in_ready/in_item) takes one transaction per cycle
//   while in_ready is high. A tick transaction yields one result on the output
//   channel (out_valid/out_ready/out_item) with the two coil levels and the steps
//   still to do. Set-count and table-write transactions yield no result and take
//   effect at acceptance, so a tick accepted in the next cycle already sees them.
//   A result passes the table read (registered at the accepting edge, together
//   with the read stage) and then the output register before the receiver can
//   take it. Throughput: one transaction per cycle while in_ready stays high,
//   set by the single table read port and the counter update.
//   Configuration (cfg_we/cfg_index/cfg_data) is for the user to write only
//   while idle; the block itself does not enforce it.
//   Reset clears the step count, the phase counter, the pipeline and the
//   registers to their defaults; table contents stay undefined until written.
//   When the receiver stalls, the output register holds the result and one
//   more tick can sit in the read stage; after that in_ready drops until the
//   output moves.
module microstep_sine_cosine_sequencer_unit
  import msc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = LEVEL_WIDTH;

  // Configuration registers.
  logic [POINTS_W-1:0] points;
  logic signed [15:0]  idle_sine;
  logic signed [15:0]  idle_cos;

  always_ff @(posedge clk) begin
    if (rst) begin
      points    <= POINTS_RESET;
      idle_sine <= '0;
      idle_cos  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POINTS:    points    <= cfg_data[POINTS_W-1:0];
        CFG_IDLE_SINE: idle_sine <= cfg_data;
        CFG_IDLE_COS:  idle_cos  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input decode.
  logic accept;
  logic tick;
  logic set;
  logic wr;
  logic out_free;
  logic s1_valid;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_free;
  assign accept   = in_valid && in_ready;
  assign tick     = accept && (in_item.opcode == OP_TICK);
  assign set      = accept && (in_item.opcode == OP_SET);
  assign wr       = accept && (in_item.opcode == OP_WRITE) &&
                    (32'(in_item.entry_index) < TABLE_DEPTH);

  // Step sequencer.
  logic [AW-1:0] rd_addr;
  seq_info_t     info;

  msc_seq #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .set        (set),
    .step_count (in_item.step_count),
    .points     (points),
    .addr       (rd_addr),
    .info       (info)
  );

  // Fit the 16-bit table entries to the stored level width, sign-extending when it is wider.
  logic [LW-1:0] wr_sine;
  logic [LW-1:0] wr_cos;

  always_comb begin
    for (int i = 0; i < LW; i++) begin
      wr_sine[i] = (i < 16) ? in_item.sine_entry[i]   : in_item.sine_entry[15];
      wr_cos[i]  = (i < 16) ? in_item.cosine_entry[i] : in_item.cosine_entry[15];
    end
  end

  // Sine and cosine tables share one RAM word.
  logic [2*LW-1:0] ram_rdata;

  msc_ram #(
    .WIDTH(2 * LW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr),
    .waddr (AW'(in_item.entry_index)),
    .wdata ({wr_sine, wr_cos}),
    .re    (tick),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Read stage: side data travels alongside the RAM read.
  logic               s1_idle;
  logic signed [31:0] s1_steps;
  logic signed [15:0] s1_idle_sine;
  logic signed [15:0] s1_idle_cos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      s1_idle      <= info.idle;
      s1_steps     <= info.steps_after;
      s1_idle_sine <= idle_sine;
      s1_idle_cos  <= idle_cos;
    end
  end

  // Bring the stored levels back to 16 bits.
  logic [15:0] rd_sine16;
  logic [15:0] rd_cos16;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      rd_sine16[i] = (i < LW) ? ram_rdata[LW + i] : ram_rdata[2*LW-1];
      rd_cos16[i]  = (i < LW) ? ram_rdata[i]      : ram_rdata[LW-1];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_item.sine_drive      <= s1_idle ? s1_idle_sine : rd_sine16;
      out_item.cosine_drive    <= s1_idle ? s1_idle_cos  : rd_cos16;
      out_item.steps_remaining <= s1_steps;
    end
  end

  // A stalled read stage must keep its RAM data.
  a_hold_rdata: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !in_ready) |=> $stable(ram_rdata))
    else $error("table read data lost while the read stage was stalled");

  // Set and write transactions never reach the read stage.
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.opcode != OP_TICK) |=> !s1_valid)
    else $error("result produced for a non-tick transaction");

endmodule

// ===== rtl/core/msc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the coil level tables.
module msc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/msc_seq.sv =====
// Step count and phase counter sequencer with table address generation.
// Depends on msc_pkg; instantiated by the sequencer top level.
module msc_seq
  import msc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tick,
  input  logic                           set,
  input  logic signed [31:0]             step_count,
  input  logic [POINTS_W-1:0]            points,
  output logic [$clog2(TABLE_DEPTH)-1:0] addr,
  output seq_info_t                      info
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic signed [31:0]  steps_left;
  logic signed [31:0]  steps_left_next;
  logic [POINTS_W-1:0] phase_counter;
  logic [POINTS_W-1:0] phase_counter_next;
  logic [POINTS_W-1:0] pts;
  logic [POINTS_W-1:0] pc_inc;
  logic [POINTS_W-1:0] idx;
  logic                wrap;
  logic signed [31:0]  steps_tick;

  // Clamp the points register to the usable table range.
  always_comb begin
    if (points < MIN_POINTS) begin
      pts = MIN_POINTS;
    end else if (32'(points) > TABLE_DEPTH) begin
      pts = POINTS_W'(TABLE_DEPTH);
    end else begin
      pts = points;
    end
  end

  // Advance the phase; reaching or passing the wrap point reads entry zero.
  always_comb begin
    pc_inc = phase_counter + POINTS_W'(1);
    wrap   = (pc_inc >= pts);
    if (wrap) begin
      idx = '0;
    end else if (steps_left > 0) begin
      idx = pc_inc;
    end else begin
      idx = pts - pc_inc;
    end
    addr = AW'(idx);
  end

  // Step count after a tick: moves one toward zero on a wrap.
  always_comb begin
    if (steps_left == 0 || !wrap) begin
      steps_tick = steps_left;
    end else if (steps_left > 0) begin
      steps_tick = steps_left - 32'sd1;
    end else begin
      steps_tick = steps_left + 32'sd1;
    end
    info.idle        = (steps_left == 0);
    info.steps_after = steps_tick;
  end

  // Next state of the counters.
  always_comb begin
    steps_left_next    = steps_left;
    phase_counter_next = phase_counter;
    if (set) begin
      steps_left_next = step_count;
    end else if (tick) begin
      steps_left_next = steps_tick;
      if (steps_left == 0 || wrap) begin
        phase_counter_next = '0;
      end else begin
        phase_counter_next = pc_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left    <= '0;
      phase_counter <= '0;
    end else begin
      steps_left    <= steps_left_next;
      phase_counter <= phase_counter_next;
    end
  end

  // An idle tick keeps the count at zero and parks the phase.
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (tick && steps_left == 0) |=> (steps_left == 0 && phase_counter == '0))
    else $error("idle tick changed the step state");

  // A forward tick lowers the count by at most one.
  a_fwd_step: assert property (@(posedge clk) disable iff (rst)
    (tick && steps_left > 0) |=>
      (steps_left == $past(steps_left) || steps_left == $past(steps_left) - 32'sd1))
    else $error("forward tick moved the count by more than one");

  // After any tick the phase lies below the wrap point.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    tick |=> (phase_counter < $past(pts)))
    else $error("phase counter past the wrap point");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the microstep sine/cosine sequencer unit.
// Depends on msc_pkg and microstep_sine_cosine_sequencer_unit; needs no files or arguments.
module tb_top;
  import msc_pkg::*;

  // Opcode 3 has no name in the package; the block must ignore it.
  localparam opcode_t OP_UNUSED = 2'd3;

  // Two copies of the sequencer state: one runs ahead while items are queued,
  // the other follows the transactions the block actually accepts.
  localparam int PLAN_COPY = 0;
  localparam int LIVE_COPY = 1;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  cfg_index_t            cfg_index = CFG_POINTS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  microstep_sine_cosine_sequencer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Sequencer state and configuration, per copy.
  logic signed [31:0] steps_left [2];
  logic [10:0]        phase_ctr [2];
  logic [10:0]        points_reg [2];
  logic signed [15:0] idle_sine [2];
  logic signed [15:0] idle_cos [2];
  logic signed [15:0] sine_tab [2][TABLE_DEPTH_DEF];
  logic signed [15:0] cos_tab [2][TABLE_DEPTH_DEF];
  bit                 written [2][TABLE_DEPTH_DEF];

  in_item_t  queued_commands [$];
  out_item_t tick_levels_q [$];
  int        commands_queued = 0;
  int        commands_accepted = 0;
  int        ticks_checked = 0;
  int        fault_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  bit        in_taken = 1'b0;

  initial begin
    for (int m = 0; m < 2; m++) begin
      steps_left[m] = '0;
      phase_ctr[m]  = '0;
      points_reg[m] = POINTS_RESET;
      idle_sine[m]  = '0;
      idle_cos[m]   = '0;
    end
  end

  // Wrap index after clamping the register to the usable range.
  function automatic logic [10:0] wrap_points(input int m);
    logic [10:0] p;
    p = points_reg[m];
    if (p < MIN_POINTS) p = MIN_POINTS;
    if (int'(p) > TABLE_DEPTH_DEF) p = 11'(TABLE_DEPTH_DEF);
    return p;
  endfunction

  // Table entry the next tick reads, or -1 when the tick drives idle levels.
  function automatic int table_index(input int m);
    logic [10:0] nxt;
    logic [10:0] pts;
    if (steps_left[m] == 0) return -1;
    pts = wrap_points(m);
    nxt = phase_ctr[m] + 11'd1;
    if (nxt >= pts) return 0;
    if (steps_left[m] > 0) return int'(nxt);
    return int'(pts - nxt);
  endfunction

  // Applies one command to a state copy; returns 1 when it yields coil levels.
  function automatic bit advance_sequencer(input int m, input in_item_t cmd,
                                           output out_item_t levels);
    int          idx;
    logic [10:0] pts;
    levels = '0;
    case (cmd.opcode)
      OP_SET: begin
        steps_left[m] = cmd.step_count;
        return 1'b0;
      end
      OP_WRITE: begin
        sine_tab[m][cmd.entry_index] = cmd.sine_entry;
        cos_tab[m][cmd.entry_index]  = cmd.cosine_entry;
        written[m][cmd.entry_index]  = 1'b1;
        return 1'b0;
      end
      OP_TICK: begin
        if (steps_left[m] == 0) begin
          levels.sine_drive   = idle_sine[m];
          levels.cosine_drive = idle_cos[m];
          phase_ctr[m] = '0;
        end else begin
          idx = table_index(m);
          pts = wrap_points(m);
          phase_ctr[m] = phase_ctr[m] + 11'd1;
          levels.sine_drive   = sine_tab[m][idx];
          levels.cosine_drive = cos_tab[m][idx];
          // The wrap tick clears the counter and moves the count toward zero.
          if (phase_ctr[m] >= pts || (steps_left[m] < 0 && idx == 0)) begin
            phase_ctr[m] = '0;
            if (steps_left[m] > 0) steps_left[m] = steps_left[m] - 1;
            else steps_left[m] = steps_left[m] + 1;
          end
        end
        levels.steps_remaining = steps_left[m];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // A command with the given opcode and count and the other fields random; callers override what matters.
  function automatic in_item_t make_cmd(input opcode_t op, input logic [31:0] steps);
    in_item_t cmd;
    cmd.opcode       = op;
    cmd.step_count   = steps;
    cmd.entry_index  = 10'($urandom_range(TABLE_DEPTH_DEF - 1));
    cmd.sine_entry   = 16'($urandom);
    cmd.cosine_entry = 16'($urandom);
    return cmd;
  endfunction

  // Queues a command. A tick that would read a never-written entry gets a
  // table write for that entry queued in front of it.
  function automatic void queue_command(input in_item_t cmd);
    in_item_t  fill;
    out_item_t ignored;
    int        idx;
    if (cmd.opcode == OP_TICK) begin
      idx = table_index(PLAN_COPY);
      if (idx >= 0 && !written[PLAN_COPY][idx]) begin
        fill = make_cmd(OP_WRITE, $urandom);
        fill.entry_index = 10'(idx);
        void'(advance_sequencer(PLAN_COPY, fill, ignored));
        queued_commands.push_back(fill);
        commands_queued++;
      end
    end
    void'(advance_sequencer(PLAN_COPY, cmd, ignored));
    queued_commands.push_back(cmd);
    commands_queued++;
  endfunction

  // Mostly ticks with short signed runs, plus writes, big counts and noise.
  function automatic in_item_t random_command();
    in_item_t cmd;
    int       r;
    int       k;
    cmd = make_cmd(OP_TICK, $urandom);
    r = $urandom_range(99);
    if (r < 3) begin
      cmd.opcode = OP_UNUSED;
    end else if (r < 9) begin
      cmd.opcode = OP_WRITE;
    end else if (r < 17) begin
      cmd.opcode = OP_SET;
      k = $urandom_range(99);
      if (k < 10) cmd.step_count = 0;
      else if (k < 13) cmd.step_count = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      else if (k < 28) cmd.step_count = $urandom;
      else if ($urandom_range(1)) cmd.step_count = $urandom_range(4, 1);
      else cmd.step_count = -$signed({1'b0, 31'($urandom_range(4, 1))});
    end
    return cmd;
  endfunction

  // Waits until every queued command is accepted and every result checked.
  task automatic wait_drained();
    while (commands_accepted != commands_queued || tick_levels_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    for (int m = 0; m < 2; m++) begin
      case (idx)
        CFG_POINTS:    points_reg[m] = data[POINTS_W-1:0];
        CFG_IDLE_SINE: idle_sine[m]  = data;
        CFG_IDLE_COS:  idle_cos[m]   = data;
        default: ;
      endcase
    end
    @(negedge clk);
  endtask

  // Drains the block, writes all registers, sets pacing, queues random commands.
  task automatic run_phase(input logic [15:0] points_word, input logic [15:0] sine_lvl,
                           input logic [15:0] cos_lvl, input int send_pct,
                           input int stall, input int count);
    wait_drained();
    repeat (4) @(negedge clk);
    send_idle_pct = send_pct;
    stall_pct     = stall;
    write_reg(CFG_POINTS, points_word);
    write_reg(CFG_IDLE_SINE, sine_lvl);
    write_reg(CFG_IDLE_COS, cos_lvl);
    cfg_we <= 1'b0;
    repeat (count) queue_command(random_command());
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: presents queued commands at the falling edge and paces the receiver.
  always @(negedge clk) begin : drive_proc
    bit busy;
    busy = in_valid && !in_taken;
    in_taken = 1'b0;
    if (!busy) begin
      if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= queued_commands.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: checks each result transaction, then predicts from each accepted command.
  always @(posedge clk) begin : observe_proc
    out_item_t want;
    out_item_t predicted;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (tick_levels_q.size() == 0) begin
          $display("%0t: result with none expected, got sine %0d cosine %0d steps %0d",
                   $time, out_item.sine_drive, out_item.cosine_drive,
                   out_item.steps_remaining);
          fault_count++;
        end else begin
          want = tick_levels_q.pop_front();
          ticks_checked++;
          if (out_item.sine_drive !== want.sine_drive) begin
            $display("%0t: sine_drive expected %0d, got %0d",
                     $time, want.sine_drive, out_item.sine_drive);
            fault_count++;
          end
          if (out_item.cosine_drive !== want.cosine_drive) begin
            $display("%0t: cosine_drive expected %0d, got %0d",
                     $time, want.cosine_drive, out_item.cosine_drive);
            fault_count++;
          end
          if (out_item.steps_remaining !== want.steps_remaining) begin
            $display("%0t: steps_remaining expected %0d, got %0d",
                     $time, want.steps_remaining, out_item.steps_remaining);
            fault_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (advance_sequencer(LIVE_COPY, in_item, predicted))
          tick_levels_q.push_back(predicted);
        commands_accepted++;
        in_taken = 1'b1;
      end
    end
  end

  // Stimulus: directed cases first, then random phases over several settings.
  initial begin : stimulus_proc
    in_item_t cmd;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Idle tick, ignored opcode, extreme table values, full reverse cycle
    // from the most negative count.
    queue_command(make_cmd(OP_TICK, $urandom));
    queue_command(make_cmd(OP_UNUSED, $urandom));
    cmd = make_cmd(OP_WRITE, $urandom);
    cmd.entry_index  = '0;
    cmd.sine_entry   = 16'sh8000;
    cmd.cosine_entry = 16'sh7FFF;
    queue_command(cmd);
    queue_command(make_cmd(OP_SET, 32'h8000_0000));
    repeat (10) queue_command(make_cmd(OP_TICK, $urandom));

    // Upper data bits beyond the points field are dropped; forward from the
    // largest count, stopping with the counter at 10.
    run_phase(16'hF80D, 16'h8000, 16'h7FFF, 0, 0, 0);
    queue_command(make_cmd(OP_SET, 32'h7FFF_FFFF));
    repeat (10) queue_command(make_cmd(OP_TICK, $urandom));

    // Points of zero clamp to the minimum, so the counter is already past the
    // wrap point; then idle levels at the opposite extremes.
    run_phase(16'h0000, 16'h7FFF, 16'h8000, 0, 0, 0);
    queue_command(make_cmd(OP_TICK, $urandom));
    queue_command(make_cmd(OP_SET, 32'h0));
    queue_command(make_cmd(OP_TICK, $urandom));

    // Random phases: settings from the clamp limits to mid range, under all
    // pacing modes.
    run_phase(16'd17,   16'h7FFF,        16'h8000,        0,  0,  180);
    run_phase(16'hF80A, 16'($urandom),   16'($urandom),   64, 0,  180);
    run_phase(16'd1024, 16'h0000,        16'hFFFF,        0,  64, 110);
    run_phase(16'd23,   16'h8000,        16'h7FFF,        18, 18, 180);
    run_phase(16'h07FF, 16'($urandom),   16'($urandom),   64, 0,  90);
    run_phase(16'd12,   16'($urandom),   16'($urandom),   0,  64, 180);
    run_phase(16'd40,   16'($urandom),   16'($urandom),   18, 18, 180);
    run_phase(16'd5,    16'h0000,        16'h0000,        0,  0,  180);
    run_phase(16'h7C0B, 16'($urandom),   16'($urandom),   0,  64, 180);
    run_phase(16'd31,   16'($urandom),   16'($urandom),   18, 18, 180);

    wait_drained();
    repeat (8) @(negedge clk);
    $display("Run covered %0d accepted commands and %0d checked tick results,",
             commands_accepted, ticks_checked);
    $display("over thirteen register settings and four pacing modes.");
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog_proc
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
